>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define AIS_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define AIS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> rtl/ais_pkg.sv
// Package with shared constants and types of the input activity selector.
package ais_pkg;
    localparam int SAMPLE_W      = 12;
    localparam int DT_W          = 12;
    localparam int THRESH_W      = 15;
    localparam int DEV_W         = 3;
    localparam int WINDOW_DEF    = 6;
    localparam int ACT_W         = 16;
    localparam int APB_DATA_W    = 32;

    localparam logic [SAMPLE_W-1:0] POS_MAX    = 12'd4095;
    localparam logic [SAMPLE_W-1:0] POS_RESET  = 12'd2048;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd800;

    localparam logic [DEV_W-1:0] DEV_NONE   = 3'd0;
    localparam logic [DEV_W-1:0] DEV_SLIDER = 3'd1;
    localparam logic [DEV_W-1:0] DEV_KNOB   = 3'd2;
    localparam logic [DEV_W-1:0] DEV_STICK  = 3'd3;
    localparam logic [DEV_W-1:0] DEV_BUTTON = 3'd4;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    typedef logic [ACT_W-1:0]    t_activity;
    typedef logic [SAMPLE_W-1:0] t_sample;

    // Per-channel summary that feeds the device selection.
    typedef struct packed {
        t_activity activity;
        t_sample   average;
    } t_chan_stat;

    // Button request data held for the selection stage.
    typedef struct packed {
        logic            down;
        logic            up;
        logic [DT_W-1:0] dt;
    } t_button;
endpackage

>>> rtl/input_activity_selector.sv
// An accepted request waits in the button stage until the output is free.
// Throughput: one request per cycle while the output does not stall; windows
// are written on accept and read by the selection stage as the request moves on.
// Reset: synchronous and active low; it clears windows, totals, slot,
// device (none), position (2048) and sets the threshold to 800.
module input_activity_selector import ais_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // slider[11:0], knob[23:12], stick[35:24], down[36], up[37], dt[49:38]
    input  logic [55:0]            s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // position[11:0]
    output logic [15:0]            m_axis_tdata,
    // device_kind[2:0]
    output logic [DEV_W-1:0]       m_axis_tuser,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [0:0]             paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);
    localparam int SLOT_W = $clog2(WINDOW);

    logic [SLOT_W-1:0]    r_slot;
    logic [THRESH_W-1:0]  r_threshold;
    logic                 r_b_valid;
    t_button              r_button;
    logic                 r_out_valid;
    logic                 in_acc;
    logic                 b_adv;
    t_chan_stat           st_slider;
    t_chan_stat           st_knob;
    t_chan_stat           st_stick;
    t_sample              position;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_THRESHOLD) ? APB_DATA_W'(r_threshold) : '0;

    assign b_adv         = r_b_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_b_valid || b_adv);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_slot      <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_THRESHOLD) begin
                r_threshold <= pwdata[THRESH_W-1:0];
            end
            if (in_acc) begin
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
            end
            r_b_valid <= in_acc || (r_b_valid && !b_adv);
            if (b_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_button.down <= s_axis_tdata[36];
            r_button.up   <= s_axis_tdata[37];
            r_button.dt   <= s_axis_tdata[49:38];
        end
    end

    ais_window #(.WINDOW(WINDOW)) u_slider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (in_acc),
        .i_slot   (r_slot),
        .i_sample (s_axis_tdata[11:0]),
        .o_stat   (st_slider)
    );

    ais_window #(.WINDOW(WINDOW)) u_knob (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (in_acc),
        .i_slot   (r_slot),
        .i_sample (s_axis_tdata[23:12]),
        .o_stat   (st_knob)
    );

    ais_window #(.WINDOW(WINDOW)) u_stick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (in_acc),
        .i_slot   (r_slot),
        .i_sample (s_axis_tdata[35:24]),
        .o_stat   (st_stick)
    );

    ais_select u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (b_adv),
        .i_threshold (r_threshold),
        .i_slider    (st_slider),
        .i_knob      (st_knob),
        .i_stick     (st_stick),
        .i_button    (r_button),
        .o_device    (m_axis_tuser),
        .o_position  (position)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, position};
endmodule

>>> rtl/ais_window.sv
// Sample ring of one channel with running total, activity and average.
module ais_window import ais_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  logic [$clog2(WINDOW)-1:0]   i_slot,
    input  t_sample                     i_sample,
    output t_chan_stat                  o_stat
);
    localparam int TOT_W = $clog2(WINDOW * 4096);
    localparam int SHIFT = TOT_W + $clog2(WINDOW);
    localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'((2 ** SHIFT + WINDOW - 1) / WINDOW);
    localparam int PROD_W = TOT_W + SHIFT + 1;

    t_sample            r_ring [WINDOW];
    logic [TOT_W-1:0]   r_total;
    logic [PROD_W-1:0]  prod;
    t_activity          diff [WINDOW-1];
    t_activity          acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_total <= '0;
        end else if (i_wr) begin
            r_ring[i_slot] <= i_sample;
            r_total <= r_total - TOT_W'(r_ring[i_slot]) + TOT_W'(i_sample);
        end
    end

    always_comb begin
        for (int i = 0; i < WINDOW - 1; i++) begin
            if (r_ring[i] > r_ring[i+1]) begin
                diff[i] = ACT_W'(r_ring[i] - r_ring[i+1]);
            end else begin
                diff[i] = ACT_W'(r_ring[i+1] - r_ring[i]);
            end
        end
        acc = '0;
        for (int i = 0; i < WINDOW - 1; i++) begin
            acc = acc + diff[i];
        end
    end

    assign prod = PROD_W'(r_total) * PROD_W'(RECIP);
    assign o_stat.activity = acc;
    assign o_stat.average  = prod[SHIFT +: SAMPLE_W];
endmodule

>>> rtl/ais_select.sv
// Device selection and position update, holding the device and position registers.
module ais_select import ais_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [THRESH_W-1:0]  i_threshold,
    input  t_chan_stat           i_slider,
    input  t_chan_stat           i_knob,
    input  t_chan_stat           i_stick,
    input  t_button              i_button,
    output logic [DEV_W-1:0]     o_device,
    output t_sample              o_position
);
    logic [DEV_W-1:0]    r_device;
    logic [DEV_W-1:0]    n_device;
    t_sample             r_position;
    t_sample             n_position;
    t_activity           thr;
    logic signed [13:0]  step_pos;

    assign thr = ACT_W'(i_threshold);

    always_comb begin
        if (i_slider.activity > thr) begin
            n_device = DEV_SLIDER;
        end else if (i_knob.activity > thr) begin
            n_device = DEV_KNOB;
        end else if (i_stick.activity > thr) begin
            n_device = DEV_STICK;
        end else if (i_button.down || i_button.up) begin
            n_device = DEV_BUTTON;
        end else begin
            n_device = r_device;
        end

        step_pos = $signed({2'b00, r_position});
        if (i_button.down) begin
            step_pos = step_pos - $signed({2'b00, i_button.dt});
        end
        if (i_button.up) begin
            step_pos = step_pos + $signed({2'b00, i_button.dt});
        end

        case (n_device)
            DEV_SLIDER: n_position = POS_MAX - i_slider.average;
            DEV_KNOB:   n_position = i_knob.average;
            DEV_STICK:  n_position = POS_MAX - i_stick.average;
            DEV_BUTTON: begin
                if (step_pos < 0) begin
                    n_position = '0;
                end else if (step_pos > $signed({2'b00, POS_MAX})) begin
                    n_position = POS_MAX;
                end else begin
                    n_position = step_pos[SAMPLE_W-1:0];
                end
            end
            default:    n_position = r_position;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device   <= DEV_NONE;
            r_position <= POS_RESET;
        end else if (i_en) begin
            r_device   <= n_device;
            r_position <= n_position;
        end
    end

    assign o_device   = r_device;
    assign o_position = r_position;
endmodule

>>> rtl/ais_checker.sv
// Port-level checker for the input activity selector and its bind statement.
`include "assert_macros.svh"

module ais_checker import ais_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [15:0]       m_axis_tdata,
    input logic [DEV_W-1:0]  m_axis_tuser,
    input logic              pready
);
    `AIS_ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `AIS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `AIS_ASSERT_RST(a_kind_legal, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tuser <= DEV_BUTTON)
    `AIS_ASSERT_RST(a_none_holds, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == DEV_NONE |-> m_axis_tdata == {4'b0000, POS_RESET})
    `AIS_ASSERT_ALWAYS(a_pready, i_clk, pready)
endmodule

bind input_activity_selector ais_checker u_ais_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pready        (pready)
);

>>> dv/input_activity_selector_tb.sv
// Self-checking testbench for the input activity selector with a built-in position predictor.
module input_activity_selector_tb;
    import ais_pkg::*;

    localparam int WIN            = WINDOW_DEF;
    localparam int PHASE_ITEMS    = 255;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [0:0] UNMAPPED_ADDR = 1'b1;

    typedef struct packed {
        logic [DEV_W-1:0] kind;
        t_sample          position;
    } t_position_result;

    typedef struct packed {
        t_sample         slider;
        t_sample         knob;
        t_sample         stick;
        logic            down;
        logic            up;
        logic [DT_W-1:0] dt;
    } t_reading;

    class position_scoreboard;
        t_sample             slider_ring[WIN];
        t_sample             knob_ring[WIN];
        t_sample             stick_ring[WIN];
        int                  slider_sum;
        int                  knob_sum;
        int                  stick_sum;
        int                  slot;
        logic [DEV_W-1:0]    device;
        t_sample             last_pos;
        logic [THRESH_W-1:0] threshold;
        t_position_result    expected_q[$];
        int                  errors;
        int                  checked;
        int                  kind_count[5];

        function new();
            foreach (slider_ring[i]) begin
                slider_ring[i] = '0;
                knob_ring[i]   = '0;
                stick_ring[i]  = '0;
            end
            slider_sum = 0;
            knob_sum   = 0;
            stick_sum  = 0;
            slot       = 0;
            device     = DEV_NONE;
            last_pos   = POS_RESET;
            threshold  = THRESH_RESET;
            errors     = 0;
            checked    = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        function int ring_activity(t_sample ring[WIN]);
            int acc;
            int diff;
            acc = 0;
            for (int i = 0; i + 1 < WIN; i++) begin
                diff = int'(ring[i + 1]) - int'(ring[i]);
                acc += (diff < 0) ? -diff : diff;
            end
            return acc;
        endfunction

        function void note_request(t_reading r);
            int x;
            t_position_result res;
            slider_sum = slider_sum - int'(slider_ring[slot]) + int'(r.slider);
            knob_sum   = knob_sum - int'(knob_ring[slot]) + int'(r.knob);
            stick_sum  = stick_sum - int'(stick_ring[slot]) + int'(r.stick);
            slider_ring[slot] = r.slider;
            knob_ring[slot]   = r.knob;
            stick_ring[slot]  = r.stick;
            slot = (slot + 1) % WIN;

            if (ring_activity(slider_ring) > int'(threshold)) begin
                device = DEV_SLIDER;
            end else if (ring_activity(knob_ring) > int'(threshold)) begin
                device = DEV_KNOB;
            end else if (ring_activity(stick_ring) > int'(threshold)) begin
                device = DEV_STICK;
            end else if (r.down || r.up) begin
                device = DEV_BUTTON;
            end

            case (device)
                DEV_SLIDER: last_pos = t_sample'(int'(POS_MAX) - slider_sum / WIN);
                DEV_KNOB:   last_pos = t_sample'(knob_sum / WIN);
                DEV_STICK:  last_pos = t_sample'(int'(POS_MAX) - stick_sum / WIN);
                DEV_BUTTON: begin
                    x = int'(last_pos);
                    if (r.down) x -= int'(r.dt);
                    if (r.up) x += int'(r.dt);
                    if (x < 0) x = 0;
                    else if (x > int'(POS_MAX)) x = int'(POS_MAX);
                    last_pos = t_sample'(x);
                end
                default: ;
            endcase

            res.kind     = device;
            res.position = last_pos;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [DEV_W-1:0] kind, logic [15:0] data);
            t_position_result exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, got device %0d position %0d",
                         $time, kind, data);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (kind !== exp_res.kind) begin
                $display("%0t: device mismatch, expected %0d got %0d",
                         $time, exp_res.kind, kind);
                errors++;
            end
            if (data !== {4'b0000, exp_res.position}) begin
                $display("%0t: position mismatch, expected %0d got %0d",
                         $time, exp_res.position, data);
                errors++;
            end
            if (exp_res.kind <= DEV_BUTTON) kind_count[exp_res.kind]++;
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // slider[11:0], knob[23:12], stick[35:24], down[36], up[37], dt[49:38]
    logic [55:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // position[11:0]
    logic [15:0]           m_axis_tdata;
    // device_kind[2:0]
    logic [DEV_W-1:0]      m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [0:0]            paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    position_scoreboard sb = new();
    bit idle_on = 1'b1;
    int stall_left = 0;
    int idle_cycles = 0;
    int config_writes = 0;
    int chan_mode[3];
    int chan_base[3];
    int chan_amp[3];
    int press_odds;
    int dt_max;

    input_activity_selector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 3);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_reading make_reading(int s, int k, int j, bit down, bit up, int dt);
        t_reading r;
        r.slider = t_sample'(s);
        r.knob   = t_sample'(k);
        r.stick  = t_sample'(j);
        r.down   = down;
        r.up     = up;
        r.dt     = DT_W'(dt);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input t_reading r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, r.dt, r.up, r.down, r.stick, r.knob, r.slider};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(r);
    endtask

    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [0:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_THRESHOLD) sb.threshold = data[THRESH_W-1:0];
        config_writes++;
    endtask

    task automatic apb_check_threshold();
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_THRESHOLD;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DATA_W'(sb.threshold)) begin
            $display("%0t: threshold readback mismatch, expected %0d got %0d",
                     $time, sb.threshold, got);
            sb.errors++;
        end
    endtask

    task automatic reconfigure(input logic [0:0] addr, input logic [APB_DATA_W-1:0] data);
        wait_until_idle();
        apb_write(addr, data);
        apb_check_threshold();
    endtask

    task automatic new_segment();
        int r;
        for (int ch = 0; ch < 3; ch++) begin
            r = $urandom_range(0, 9);
            chan_mode[ch] = (r < 4) ? 0 : (r < 8) ? 1 : 2;
            chan_amp[ch]  = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 600)
                                                        : $urandom_range(1, 80);
            if ($urandom_range(0, 4) == 0) begin
                chan_base[ch] = $urandom_range(0, 1) ? int'(POS_MAX) : 0;
            end else begin
                chan_base[ch] = $urandom_range(0, 4095);
            end
        end
        press_odds = $urandom_range(0, 4);
        dt_max     = ($urandom_range(0, 3) == 0) ? 4095 : 300;
        idle_on   <= ($urandom_range(0, 3) != 0);
    endtask

    function automatic t_sample next_sample(input int ch);
        int v;
        case (chan_mode[ch])
            0: v = chan_base[ch];
            1: begin
                v = chan_base[ch] + int'($urandom_range(0, 2 * chan_amp[ch])) - chan_amp[ch];
                if (v < 0) v = 0;
                else if (v > int'(POS_MAX)) v = int'(POS_MAX);
                chan_base[ch] = v;
            end
            default: v = $urandom_range(0, 4095);
        endcase
        return t_sample'(v);
    endfunction

    task automatic run_random(input int count);
        int seg_left;
        t_reading r;
        seg_left = 0;
        repeat (count) begin
            if (seg_left == 0) begin
                new_segment();
                seg_left = $urandom_range(5, 40);
            end
            seg_left--;
            r.slider = next_sample(0);
            r.knob   = next_sample(1);
            r.stick  = next_sample(2);
            r.down   = ($urandom_range(0, 3) < press_odds);
            r.up     = ($urandom_range(0, 3) < press_odds);
            r.dt     = DT_W'($urandom_range(0, dt_max));
            send_request(r);
        end
    endtask

    task automatic run_directed();
        send_request(make_reading(0, 0, 0, 0, 0, 0));
        send_request(make_reading(0, 0, 0, 0, 1, 4095));
        send_request(make_reading(0, 0, 0, 1, 0, 4095));
        send_request(make_reading(0, 0, 0, 1, 1, 1234));
        send_request(make_reading(0, 0, 0, 0, 1, 5));
        send_request(make_reading(0, 4095, 0, 0, 0, 0));
        send_request(make_reading(0, 4095, 4095, 1, 0, 100));
        // The knob window flattens while the joystick still holds one step.
        repeat (4) send_request(make_reading(0, 4095, 0, 0, 1, 300));
        send_request(make_reading(4095, 0, 0, 1, 1, 7));
        repeat (6) send_request(make_reading(4095, 4095, 4095, 1, 1, 4095));
        // Joystick activity below the threshold, then above it.
        repeat (2) send_request(make_reading(4095, 4095, 3695, 0, 0, 0));
        send_request(make_reading(4095, 4095, 3294, 1, 0, 4095));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(PHASE_ITEMS);
        reconfigure(REG_THRESHOLD, 32'd0);
        run_random(PHASE_ITEMS);
        reconfigure(REG_THRESHOLD, 32'd20475);
        run_random(PHASE_ITEMS);
        reconfigure(REG_THRESHOLD, $urandom | 32'h0000_7FFF);
        run_random(PHASE_ITEMS);
        reconfigure(REG_THRESHOLD, $urandom_range(200, 2000));
        run_random(PHASE_ITEMS);
        reconfigure(UNMAPPED_ADDR, $urandom);
        reconfigure(REG_THRESHOLD, $urandom_range(0, 20475));
        run_random(PHASE_ITEMS);

        wait_until_idle();
        $display("Checked %0d results across %0d register writes.", sb.checked, config_writes);
        $display("Results per device none/slider/knob/joystick/button: %0d/%0d/%0d/%0d/%0d",
                 sb.kind_count[0], sb.kind_count[1], sb.kind_count[2],
                 sb.kind_count[3], sb.kind_count[4]);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

>>> input_activity_selector.f
+incdir+rtl
rtl/ais_pkg.sv
rtl/ais_window.sv
rtl/ais_select.sv
rtl/input_activity_selector.sv
rtl/ais_checker.sv
dv/input_activity_selector_tb.sv
